### hdl/dxt_pkg.sv
// Shared types, mode codes and fixed-point helpers for the DXT block decoder.
`timescale 1ns / 1ps

package dxt_pkg;

  localparam logic [1:0] MODE_DXT1 = 2'd0;
  localparam logic [1:0] MODE_DXT3 = 2'd1;
  localparam logic [1:0] MODE_DXT5 = 2'd2;

  localparam int unsigned PIXELS = 16;
  localparam int unsigned PIX_W  = $clog2(PIXELS);

  typedef struct packed {
    logic [15:0] color_end0;
    logic [15:0] color_end1;
    logic [31:0] color_indices;
    logic [63:0] alpha_bits;
  } blk_t;

  typedef struct packed {
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [7:0]       alpha_out;
    logic [PIX_W-1:0] pixel_index;
    logic             last;
  } pix_t;

  // Per-block decode context: colour palette (channel 2 red, 1 green, 0 blue),
  // colour-palette alpha, alpha palette, and the raw index words.
  typedef struct packed {
    logic [1:0]            mode;
    logic [3:0][2:0][7:0]  rgb;
    logic [3:0][7:0]       calpha;
    logic [7:0][7:0]       apal;
    logic [31:0]           color_indices;
    logic [63:0]           alpha_bits;
  } pal_t;

  function automatic logic [2:0][7:0] expand565(input logic [15:0] v);
    logic [2:0][7:0] rgb;
    rgb[2] = {v[15:11], v[15:13]};
    rgb[1] = {v[10:5], v[10:9]};
    rgb[0] = {v[4:0], v[4:2]};
    return rgb;
  endfunction

  // x / 3 for x <= 765 by reciprocal multiply.
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [20:0] p;
    p = 21'(x) * 21'd683;
    return p[18:11];
  endfunction

  // x / 7 for x <= 1785 by reciprocal multiply.
  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [23:0] p;
    p = 24'(x) * 24'd4682;
    return p[22:15];
  endfunction

  // x / 5 for x <= 1275 by reciprocal multiply.
  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [23:0] p;
    p = 24'(x) * 24'd6554;
    return p[22:15];
  endfunction

endpackage

### hdl/dxt_palette.sv
// Builds the colour and alpha palettes of one compressed block.
`timescale 1ns / 1ps

module dxt_palette (
  input  dxt_pkg::blk_t  blk,
  input  logic [1:0]     mode,
  output dxt_pkg::pal_t  pal
);
  import dxt_pkg::*;

  logic            four;
  logic [2:0][7:0] c0;
  logic [2:0][7:0] c1;
  logic [7:0]      a0;
  logic [7:0]      a1;

  assign four = (mode == MODE_DXT3) || (mode == MODE_DXT5) ||
                (blk.color_end0 > blk.color_end1);
  assign c0   = expand565(blk.color_end0);
  assign c1   = expand565(blk.color_end1);
  assign a0   = blk.alpha_bits[7:0];
  assign a1   = blk.alpha_bits[15:8];

  always_comb begin
    pal = '0;
    pal.mode          = mode;
    pal.color_indices = blk.color_indices;
    pal.alpha_bits    = blk.alpha_bits;
    pal.rgb[0]        = c0;
    pal.rgb[1]        = c1;
    for (int ch = 0; ch < 3; ch++) begin
      if (four) begin
        pal.rgb[2][ch] = div3({1'b0, c0[ch], 1'b0} + 10'(c1[ch]));
        pal.rgb[3][ch] = div3(10'(c0[ch]) + {1'b0, c1[ch], 1'b0});
      end else begin
        pal.rgb[2][ch] = 8'((9'(c0[ch]) + 9'(c1[ch])) >> 1);
        pal.rgb[3][ch] = 8'd0;
      end
    end
    pal.calpha[0] = 8'hFF;
    pal.calpha[1] = 8'hFF;
    pal.calpha[2] = 8'hFF;
    pal.calpha[3] = four ? 8'hFF : 8'h00;

    pal.apal[0] = a0;
    pal.apal[1] = a1;
    if (a0 > a1) begin
      for (int k = 1; k <= 6; k++) begin
        pal.apal[k+1] = div7(11'(a0) * 11'(7 - k) + 11'(a1) * 11'(k));
      end
    end else begin
      for (int k = 1; k <= 4; k++) begin
        pal.apal[k+1] = div5(11'(a0) * 11'(5 - k) + 11'(a1) * 11'(k));
      end
      pal.apal[6] = 8'h00;
      pal.apal[7] = 8'hFF;
    end
  end

endmodule

### hdl/dxt_pixel.sv
// Selects one pixel's colour and alpha out of a decoded block palette.
`timescale 1ns / 1ps

module dxt_pixel (
  input  dxt_pkg::pal_t                pal,
  input  logic [dxt_pkg::PIX_W-1:0]    pix_num,
  output dxt_pkg::pix_t                pix
);
  import dxt_pkg::*;

  logic [1:0] ci;
  logic [3:0] a4;
  logic [2:0] ai;

  assign ci = pal.color_indices[2*pix_num +: 2];
  assign a4 = pal.alpha_bits[4*pix_num +: 4];
  assign ai = pal.alpha_bits[16 + 3*pix_num +: 3];

  always_comb begin
    pix.red         = pal.rgb[ci][2];
    pix.green       = pal.rgb[ci][1];
    pix.blue        = pal.rgb[ci][0];
    pix.pixel_index = pix_num;
    pix.last        = (pix_num == PIX_W'(PIXELS - 1));
    case (pal.mode)
      MODE_DXT3: pix.alpha_out = {a4, a4};   // a4 * 255 / 15 is exactly a4 * 17
      MODE_DXT5: pix.alpha_out = pal.apal[ai];
      default:   pix.alpha_out = pal.calpha[ci];
    endcase
  end

endmodule

### hdl/dxt_texture_block_decoder_top.sv
// Top level of the DXT1/DXT3/DXT5 texture block decoder.
`timescale 1ns / 1ps

// Channel | Direction | Handshake             | Payload
// --------+-----------+-----------------------+------------------------------
// blk     | in        | blk_valid / blk_ready | dxt_pkg::blk_t, one 4x4 block
// pix     | out       | pix_valid / pix_ready | dxt_pkg::pix_t, one pixel
// cfg     | in        | cfg_valid / cfg_ready | block_mode, 2 bits
//
// A block transaction builds both palettes in the accepting cycle and holds
// them in the block register; while pix does not stall, one pixel a cycle
// then goes to the result register, set by the one-pixel result channel.
// The next block is taken in the cycle the sixteenth pixel is issued.
// Reset (synchronous) empties both registers and sets block_mode to DXT1.
// A stall on pix holds the result register and the pixel counter.

module dxt_texture_block_decoder_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 blk_valid,
  output logic                 blk_ready,
  input  dxt_pkg::blk_t        blk,
  output logic                 pix_valid,
  input  logic                 pix_ready,
  output dxt_pkg::pix_t        pix,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_data
);
  import dxt_pkg::*;

  logic [1:0]       block_mode;
  pal_t             pal_next;
  pal_t             hold;
  logic             hold_valid;
  logic [PIX_W-1:0] count;
  pix_t             pix_next;
  logic             advance;
  logic             final_pix;
  logic             blk_take;

  // Configuration is always accepted.
  assign cfg_ready = 1'b1;

  dxt_palette u_palette (
    .blk  (blk),
    .mode (block_mode),
    .pal  (pal_next)
  );

  dxt_pixel u_pixel (
    .pal     (hold),
    .pix_num (count),
    .pix     (pix_next)
  );

  // Issue a pixel whenever a block is held and the result register is free
  // or being drained this cycle.
  assign advance   = hold_valid && (!pix_valid || pix_ready);
  assign final_pix = (count == PIX_W'(PIXELS - 1));
  assign blk_ready = !hold_valid || (advance && final_pix);
  assign blk_take  = blk_valid && blk_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_mode <= MODE_DXT1;
    end else if (cfg_valid && cfg_ready) begin
      block_mode <= cfg_data;
    end
  end

  // Block register and pixel counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      count      <= '0;
    end else begin
      if (blk_take) begin
        hold_valid <= 1'b1;
        count      <= '0;
      end else if (advance) begin
        count <= count + 1'b1;
        if (final_pix) begin
          hold_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (blk_take) begin
      hold <= pal_next;
    end
  end

  // Result register: load on advance, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (advance) begin
      pix_valid <= 1'b1;
    end else if (pix_ready) begin
      pix_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pix <= pix_next;
    end
  end

endmodule
